// File: rtl/stt_pkg.sv
// Shared definitions for the countdown timer table: field widths, request
// and response codes, and the command and status structs between the units.
// No dependencies.
package stt_pkg;

	// Field widths of the request and response words.
	localparam int REQ_TYPE_W = 3;
	localparam int ENTRY_W    = 4;
	localparam int QUEUE_W    = 8;
	localparam int TAG_W      = 8;
	localparam int TICKS_W    = 32;
	localparam int KIND_W     = 3;
	localparam int SLICE_W    = 5;

	// Table sizing. The index fields address sixteen entries at most.
	localparam int DEF_NUM_TIMERS = 16;
	localparam int MAX_ENTRIES    = 16;

	// Configuration port.
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 32;
	localparam logic REG_SLICE_TIMER = 1'b0;
	localparam logic [SLICE_W-1:0] SLICE_RESET = 5'd16;

	// Request types.
	localparam logic [REQ_TYPE_W-1:0] REQ_TICK        = 3'd0;
	localparam logic [REQ_TYPE_W-1:0] REQ_ALLOC       = 3'd1;
	localparam logic [REQ_TYPE_W-1:0] REQ_FREE        = 3'd2;
	localparam logic [REQ_TYPE_W-1:0] REQ_INIT        = 3'd3;
	localparam logic [REQ_TYPE_W-1:0] REQ_SET_TIMEOUT = 3'd4;

	// Response kinds.
	localparam logic [KIND_W-1:0] KIND_GRANT     = 3'd0;
	localparam logic [KIND_W-1:0] KIND_FAIL      = 3'd1;
	localparam logic [KIND_W-1:0] KIND_ACK       = 3'd2;
	localparam logic [KIND_W-1:0] KIND_EXPIRY    = 3'd3;
	localparam logic [KIND_W-1:0] KIND_IDLE_TICK = 3'd4;

	// Datapath operations issued by the controller.
	typedef enum logic [2:0] {
		OP_NONE,
		OP_CAPTURE,
		OP_SIMPLE,
		OP_TICK_STEP,
		OP_TICK_END,
		OP_ALLOC_STEP
	} stt_op_t;

	typedef struct packed {
		stt_op_t op;
	} stt_cmd_t;

	// Datapath status seen by the controller.
	typedef struct packed {
		logic hit;         // current scan entry expires (tick) or is free (alloc)
		logic scan_end;    // scan pointer is on the last entry
		logic out_free;    // output register can take a word this cycle
		logic held_valid;  // an expiry word is waiting for its last flag
	} stt_stat_t;

endpackage

// File: rtl/stt_if.sv
// Handshake channels of the timer table: the request channel and the
// response channel, each with valid, ready and its payload. Uses stt_pkg.

interface stt_req_if import stt_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [REQ_TYPE_W-1:0] req_type;
	logic [ENTRY_W-1:0]    timer_index;
	logic [QUEUE_W-1:0]    dest_queue;
	logic [TAG_W-1:0]      tag_data;
	logic [TICKS_W-1:0]    timeout_ticks;

	modport source (output valid, req_type, timer_index, dest_queue, tag_data,
		timeout_ticks, input ready);
	modport sink (input valid, req_type, timer_index, dest_queue, tag_data,
		timeout_ticks, output ready);
endinterface

interface stt_resp_if import stt_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [KIND_W-1:0]  resp_kind;
	logic [ENTRY_W-1:0] entry_index;
	logic [QUEUE_W-1:0] notify_queue;
	logic [TAG_W-1:0]   notify_tag;
	logic               slice_switch;
	logic [TICKS_W-1:0] tick_total;
	logic               last;

	modport source (output valid, resp_kind, entry_index, notify_queue, notify_tag,
		slice_switch, tick_total, last, input ready);
	modport sink (input valid, resp_kind, entry_index, notify_queue, notify_tag,
		slice_switch, tick_total, last, output ready);
endinterface

// File: rtl/stt_apb_regs.sv
// APB-style configuration register of the timer table: the slice timer index.
// Uses stt_pkg.
module stt_apb_regs import stt_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready,
	output logic [SLICE_W-1:0]    slice_index
);

	logic [SLICE_W-1:0] slice_q;
	logic               reg_sel;

	// Registers sit on 32-bit words, so the word index starts at bit 2.
	assign reg_sel = (paddr[CFG_ADDR_W-1:2] == REG_SLICE_TIMER);

	// The register is written in the access phase of a write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slice_q <= SLICE_RESET;
		end else if (psel && penable && pwrite && reg_sel) begin
			slice_q <= pwdata[SLICE_W-1:0];
		end
	end

	assign prdata      = reg_sel ? CFG_DATA_W'(slice_q) : '0;
	assign pready      = 1'b1;
	assign slice_index = slice_q;

endmodule

// File: rtl/stt_ctrl.sv
// Controller of the timer table: sequences capture, the entry scans of tick
// and alloc, and the single-step requests. Uses stt_pkg.
module stt_ctrl import stt_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic [REQ_TYPE_W-1:0] in_req_type,
	output logic                  in_ready,
	input  stt_stat_t             stat,
	output stt_cmd_t              cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SIMPLE,
		S_TICK,
		S_TICK_END,
		S_ALLOC
	} state_t;

	state_t state_q;
	logic   ready_q;

	// Command decode: a step that would emit a word waits for the output register.
	always_comb begin
		cmd.op = OP_NONE;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.op = OP_CAPTURE;
				end
			end
			S_SIMPLE: begin
				if (stat.out_free) begin
					cmd.op = OP_SIMPLE;
				end
			end
			S_TICK: begin
				if (!(stat.hit && stat.held_valid) || stat.out_free) begin
					cmd.op = OP_TICK_STEP;
				end
			end
			S_TICK_END: begin
				if (stat.out_free) begin
					cmd.op = OP_TICK_END;
				end
			end
			S_ALLOC: begin
				if (!(stat.hit || stat.scan_end) || stat.out_free) begin
					cmd.op = OP_ALLOC_STEP;
				end
			end
			default: cmd.op = OP_NONE;
		endcase
	end

	// State register and the registered ready flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ready_q <= 1'b1;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						ready_q <= 1'b0;
						if (in_req_type == REQ_TICK) begin
							state_q <= S_TICK;
						end else if (in_req_type == REQ_ALLOC) begin
							state_q <= S_ALLOC;
						end else begin
							state_q <= S_SIMPLE;
						end
					end
				end
				S_SIMPLE: begin
					if (stat.out_free) begin
						state_q <= S_IDLE;
						ready_q <= 1'b1;
					end
				end
				S_TICK: begin
					if (cmd.op == OP_TICK_STEP && stat.scan_end) begin
						state_q <= S_TICK_END;
					end
				end
				S_TICK_END: begin
					if (stat.out_free) begin
						state_q <= S_IDLE;
						ready_q <= 1'b1;
					end
				end
				S_ALLOC: begin
					if (cmd.op == OP_ALLOC_STEP && (stat.hit || stat.scan_end)) begin
						state_q <= S_IDLE;
						ready_q <= 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
					ready_q <= 1'b1;
				end
			endcase
		end
	end

	assign in_ready = ready_q;

endmodule

// File: rtl/stt_datapath.sv
// Datapath of the timer table: the entry tables, the tick counter, the scan
// pointer, the held expiry word and the output register. Uses stt_pkg.
module stt_datapath import stt_pkg::*; #(
	parameter int NUM_TIMERS = DEF_NUM_TIMERS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  stt_cmd_t              cmd,
	output stt_stat_t             stat,
	input  logic [REQ_TYPE_W-1:0] in_req_type,
	input  logic [ENTRY_W-1:0]    in_timer_index,
	input  logic [QUEUE_W-1:0]    in_dest_queue,
	input  logic [TAG_W-1:0]      in_tag_data,
	input  logic [TICKS_W-1:0]    in_timeout_ticks,
	input  logic [SLICE_W-1:0]    slice_index,
	input  logic                  out_ready,
	output logic                  out_valid,
	output logic [KIND_W-1:0]     out_kind,
	output logic [ENTRY_W-1:0]    out_index,
	output logic [QUEUE_W-1:0]    out_queue,
	output logic [TAG_W-1:0]      out_tag,
	output logic                  out_switch,
	output logic [TICKS_W-1:0]    out_ticks,
	output logic                  out_last
);

	localparam int TABLE_SIZE = (NUM_TIMERS < MAX_ENTRIES) ? NUM_TIMERS : MAX_ENTRIES;
	localparam int IDX_W = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
	localparam logic [ENTRY_W:0] TABLE_LIMIT = (ENTRY_W+1)'(TABLE_SIZE);
	localparam logic [IDX_W-1:0] LAST_ENTRY  = IDX_W'(TABLE_SIZE - 1);

	typedef enum logic [1:0] {
		ST_FREE,
		ST_ALLOC,
		ST_RUN
	} entry_state_t;

	// Entry tables.
	entry_state_t       status_q    [TABLE_SIZE];
	logic [TICKS_W-1:0] remaining_q [TABLE_SIZE];
	logic [QUEUE_W-1:0] queue_q     [TABLE_SIZE];
	logic [TAG_W-1:0]   tag_q       [TABLE_SIZE];
	logic [TICKS_W-1:0] tick_count_q;

	// Captured request.
	logic [REQ_TYPE_W-1:0] req_type_q;
	logic [ENTRY_W-1:0]    req_idx_q;
	logic [QUEUE_W-1:0]    req_queue_q;
	logic [TAG_W-1:0]      req_tag_q;
	logic [TICKS_W-1:0]    req_ticks_q;

	// Scan pointer and the expiry word held until its last flag is known.
	logic [IDX_W-1:0]   scan_q;
	logic               held_valid_q;
	logic [ENTRY_W-1:0] held_idx_q;
	logic [QUEUE_W-1:0] held_queue_q;
	logic [TAG_W-1:0]   held_tag_q;
	logic               held_switch_q;

	// Output register.
	logic               out_valid_q;
	logic [KIND_W-1:0]  out_kind_q;
	logic [ENTRY_W-1:0] out_idx_q;
	logic [QUEUE_W-1:0] out_queue_q;
	logic [TAG_W-1:0]   out_tag_q;
	logic               out_switch_q;
	logic [TICKS_W-1:0] out_ticks_q;
	logic               out_last_q;

	logic               req_in_range;
	logic [IDX_W-1:0]   req_addr;
	entry_state_t       cur_status;
	logic [TICKS_W-1:0] rem_dec;
	logic               expire_now;
	logic               hit;
	logic               scan_end;
	logic               out_free;
	logic               cur_switch;

	logic               push;
	logic [KIND_W-1:0]  push_kind;
	logic [ENTRY_W-1:0] push_idx;
	logic [QUEUE_W-1:0] push_queue;
	logic [TAG_W-1:0]   push_tag;
	logic               push_switch;
	logic               push_last;

	// Request address check and the scanned entry.
	assign req_in_range = ({1'b0, req_idx_q} < TABLE_LIMIT);
	assign req_addr     = req_idx_q[IDX_W-1:0];
	assign cur_status   = status_q[scan_q];
	assign rem_dec      = remaining_q[scan_q] - TICKS_W'(1);
	assign expire_now   = (cur_status == ST_RUN) && (rem_dec == '0);
	assign hit          = (req_type_q == REQ_TICK) ? expire_now : (cur_status == ST_FREE);
	assign scan_end     = (scan_q == LAST_ENTRY);
	assign out_free     = !out_valid_q || out_ready;
	assign cur_switch   = (SLICE_W'(scan_q) == slice_index);

	assign stat.hit        = hit;
	assign stat.scan_end   = scan_end;
	assign stat.out_free   = out_free;
	assign stat.held_valid = held_valid_q;

	// Word to load into the output register this cycle, if any.
	always_comb begin
		push        = 1'b0;
		push_kind   = KIND_ACK;
		push_idx    = '0;
		push_queue  = '0;
		push_tag    = '0;
		push_switch = 1'b0;
		push_last   = 1'b1;
		case (cmd.op)
			OP_SIMPLE: begin
				push     = 1'b1;
				push_idx = req_idx_q;
			end
			OP_TICK_STEP: begin
				// A new expiry means the held one was not the last.
				if (expire_now && held_valid_q) begin
					push        = 1'b1;
					push_kind   = KIND_EXPIRY;
					push_idx    = held_idx_q;
					push_queue  = held_queue_q;
					push_tag    = held_tag_q;
					push_switch = held_switch_q;
					push_last   = 1'b0;
				end
			end
			OP_TICK_END: begin
				push = 1'b1;
				if (held_valid_q) begin
					push_kind   = KIND_EXPIRY;
					push_idx    = held_idx_q;
					push_queue  = held_queue_q;
					push_tag    = held_tag_q;
					push_switch = held_switch_q;
				end else begin
					push_kind = KIND_IDLE_TICK;
				end
			end
			OP_ALLOC_STEP: begin
				if (hit) begin
					push      = 1'b1;
					push_kind = KIND_GRANT;
					push_idx  = ENTRY_W'(scan_q);
				end else if (scan_end) begin
					push      = 1'b1;
					push_kind = KIND_FAIL;
				end
			end
			default: push = 1'b0;
		endcase
	end

	// Control state, entry status and destination queues.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TABLE_SIZE; i++) begin
				status_q[i] <= ST_FREE;
				queue_q[i]  <= '0;
			end
			tick_count_q <= '0;
			scan_q       <= '0;
			held_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			case (cmd.op)
				OP_CAPTURE: begin
					scan_q       <= '0;
					held_valid_q <= 1'b0;
					if (in_req_type == REQ_TICK) begin
						tick_count_q <= tick_count_q + TICKS_W'(1);
					end
				end
				OP_SIMPLE: begin
					if (req_in_range) begin
						case (req_type_q)
							REQ_FREE:        status_q[req_addr] <= ST_FREE;
							REQ_INIT:        queue_q[req_addr]  <= req_queue_q;
							REQ_SET_TIMEOUT: status_q[req_addr] <= ST_RUN;
							default:         ;
						endcase
					end
				end
				OP_TICK_STEP: begin
					if (expire_now) begin
						status_q[scan_q] <= ST_ALLOC;
						held_valid_q     <= 1'b1;
					end
					scan_q <= scan_q + IDX_W'(1);
				end
				OP_TICK_END: begin
					held_valid_q <= 1'b0;
				end
				OP_ALLOC_STEP: begin
					if (hit) begin
						status_q[scan_q] <= ST_ALLOC;
					end else begin
						scan_q <= scan_q + IDX_W'(1);
					end
				end
				default: ;
			endcase
			if (push) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers: request, counts, tags, held word and output word.
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_CAPTURE: begin
				req_type_q  <= in_req_type;
				req_idx_q   <= in_timer_index;
				req_queue_q <= in_dest_queue;
				req_tag_q   <= in_tag_data;
				req_ticks_q <= in_timeout_ticks;
			end
			OP_SIMPLE: begin
				if (req_in_range && req_type_q == REQ_INIT) begin
					tag_q[req_addr] <= req_tag_q;
				end
				if (req_in_range && req_type_q == REQ_SET_TIMEOUT) begin
					remaining_q[req_addr] <= req_ticks_q;
				end
			end
			OP_TICK_STEP: begin
				if (cur_status == ST_RUN) begin
					remaining_q[scan_q] <= rem_dec;
				end
				if (expire_now) begin
					held_idx_q    <= ENTRY_W'(scan_q);
					held_queue_q  <= queue_q[scan_q];
					held_tag_q    <= tag_q[scan_q];
					held_switch_q <= cur_switch;
				end
			end
			default: ;
		endcase
		if (push) begin
			out_kind_q   <= push_kind;
			out_idx_q    <= push_idx;
			out_queue_q  <= push_queue;
			out_tag_q    <= push_tag;
			out_switch_q <= push_switch;
			out_ticks_q  <= tick_count_q;
			out_last_q   <= push_last;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_kind   = out_kind_q;
	assign out_index  = out_idx_q;
	assign out_queue  = out_queue_q;
	assign out_tag    = out_tag_q;
	assign out_switch = out_switch_q;
	assign out_ticks  = out_ticks_q;
	assign out_last   = out_last_q;

endmodule

// File: rtl/software_timer_table.sv
// Countdown timer table. A tick or an alloc scans the entries one per cycle while
// the output register takes its words; a new request is accepted only once the last
// is done. Each word is registered at the step that makes it, except an expiry, which is
// held until the next expiry or the end of the scan. Reset frees all entries, clears
// the destination queues and tick counter and sets the slice index to 16.
module software_timer_table import stt_pkg::*; #(
	parameter int NUM_TIMERS = DEF_NUM_TIMERS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	stt_req_if.sink               req,
	stt_resp_if.source            resp,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready
);

	stt_cmd_t           cmd;
	stt_stat_t          stat;
	logic [SLICE_W-1:0] slice_index;

	// Configuration register.
	stt_apb_regs u_regs (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.slice_index (slice_index)
	);

	// Sequencer.
	stt_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (req.valid),
		.in_req_type (req.req_type),
		.in_ready    (req.ready),
		.stat        (stat),
		.cmd         (cmd)
	);

	// Tables and output word.
	stt_datapath #(
		.NUM_TIMERS (NUM_TIMERS)
	) u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.stat             (stat),
		.in_req_type      (req.req_type),
		.in_timer_index   (req.timer_index),
		.in_dest_queue    (req.dest_queue),
		.in_tag_data      (req.tag_data),
		.in_timeout_ticks (req.timeout_ticks),
		.slice_index      (slice_index),
		.out_ready        (resp.ready),
		.out_valid        (resp.valid),
		.out_kind         (resp.resp_kind),
		.out_index        (resp.entry_index),
		.out_queue        (resp.notify_queue),
		.out_tag          (resp.notify_tag),
		.out_switch       (resp.slice_switch),
		.out_ticks        (resp.tick_total),
		.out_last         (resp.last)
	);

endmodule

// File: rtl/stt_checker.sv
// Port-level checks of the timer table, attached to the top level by bind.
// Uses stt_pkg and the top level software_timer_table.
module stt_checker import stt_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               req_valid,
	input logic               req_ready,
	input logic               resp_valid,
	input logic               resp_ready,
	input logic [KIND_W-1:0]  resp_kind,
	input logic [ENTRY_W-1:0] entry_index,
	input logic [QUEUE_W-1:0] notify_queue,
	input logic [TAG_W-1:0]   notify_tag,
	input logic               slice_switch,
	input logic [TICKS_W-1:0] tick_total,
	input logic               last
);

	// A stalled response word holds.
	a_resp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		resp_valid && !resp_ready |=> resp_valid && $stable(resp_kind)
			&& $stable(entry_index) && $stable(tick_total) && $stable(last))
		else $error("response word changed while stalled");

	// The table works on one request at a time.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted while the previous one is in progress");

	// Only an expiry may request a task switch.
	a_switch_on_expiry: assert property (@(posedge clk) disable iff (!arst_n)
		resp_valid && slice_switch |-> resp_kind == KIND_EXPIRY)
		else $error("task switch on a word that is not an expiry");

	// Words other than expiries carry no destination and end their request.
	a_plain_fields: assert property (@(posedge clk) disable iff (!arst_n)
		resp_valid && resp_kind != KIND_EXPIRY |->
			notify_queue == '0 && notify_tag == '0 && last)
		else $error("non-expiry word with destination data or without last");

endmodule

bind software_timer_table stt_checker u_stt_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.req_valid    (req.valid),
	.req_ready    (req.ready),
	.resp_valid   (resp.valid),
	.resp_ready   (resp.ready),
	.resp_kind    (resp.resp_kind),
	.entry_index  (resp.entry_index),
	.notify_queue (resp.notify_queue),
	.notify_tag   (resp.notify_tag),
	.slice_switch (resp.slice_switch),
	.tick_total   (resp.tick_total),
	.last         (resp.last)
);

// File: tb/testbench.sv
// Self-checking bench for the countdown timer table: a directed walk through
// allocation, init, timeouts and ticks, then random traffic in several slice
// settings. Depends on stt_pkg, stt_if and software_timer_table.
module testbench;
	import stt_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// Request codes that the block acknowledges and otherwise ignores.
	localparam logic [REQ_TYPE_W-1:0] REQ_RESERVED_LO = 3'd5;
	localparam logic [REQ_TYPE_W-1:0] REQ_RESERVED_HI = 3'd7;

	localparam logic [CFG_ADDR_W-1:0] SLICE_ADDR = CFG_ADDR_W'(4 * int'(REG_SLICE_TIMER));
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int WATCHDOG_LIMIT  = 3000;
	localparam int DRAIN_CYCLES    = 2 * MAX_ENTRIES + 6;
	localparam int MAX_REPORTS     = 10;
	localparam int NPLAN           = 25;

	typedef enum logic [1:0] {
		SLOT_FREE,
		SLOT_ALLOCATED,
		SLOT_RUNNING
	} slot_state_t;

	typedef struct packed {
		logic [REQ_TYPE_W-1:0] req_type;
		logic [ENTRY_W-1:0]    timer_index;
		logic [QUEUE_W-1:0]    dest_queue;
		logic [TAG_W-1:0]      tag_data;
		logic [TICKS_W-1:0]    timeout_ticks;
	} request_t;

	typedef struct packed {
		logic [KIND_W-1:0]  resp_kind;
		logic [ENTRY_W-1:0] entry_index;
		logic [QUEUE_W-1:0] notify_queue;
		logic [TAG_W-1:0]   notify_tag;
		logic               slice_switch;
		logic [TICKS_W-1:0] tick_total;
		logic               last;
	} result_t;

	// One row of the directed walk. Where hand is set, the single word that
	// the row causes is checked against the kind, entry and tick total given.
	typedef struct packed {
		request_t           req;
		logic               hand;
		logic [KIND_W-1:0]  hand_kind;
		logic [ENTRY_W-1:0] hand_entry;
		logic [TICKS_W-1:0] hand_total;
	} plan_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [CFG_ADDR_W-1:0] paddr;
	logic [CFG_DATA_W-1:0] pwdata;
	logic [CFG_DATA_W-1:0] prdata;
	logic pready;

	stt_req_if  req_ch();
	stt_resp_if resp_ch();

	software_timer_table u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch),
		.resp    (resp_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Own copy of the timer table, used to work out the expected words.
	slot_state_t        slot_state [MAX_ENTRIES];
	logic [TICKS_W-1:0] slot_remaining [MAX_ENTRIES];
	logic [QUEUE_W-1:0] slot_queue [MAX_ENTRIES];
	logic [TAG_W-1:0]   slot_tag [MAX_ENTRIES];
	bit                 slot_tag_written [MAX_ENTRIES];
	logic [TICKS_W-1:0] ticks_seen;
	logic [SLICE_W-1:0] slice_index;

	result_t pending_results [$];
	int      mismatches = 0;
	int      burst_left = 0;
	int      stall_cycles = 0;
	bit      hold_off_req = 1'b0;

	plan_row_t plan [NPLAN] = '{
		'{'{REQ_TICK,        4'd0,  8'h00, 8'h00, 32'd0},        1'b1, KIND_IDLE_TICK, 4'd0,  32'd1},
		'{'{REQ_ALLOC,       4'd9,  8'h00, 8'h00, 32'd0},        1'b1, KIND_GRANT,     4'd0,  32'd1},
		'{'{REQ_ALLOC,       4'd0,  8'h00, 8'h00, 32'd0},        1'b1, KIND_GRANT,     4'd1,  32'd1},
		'{'{REQ_ALLOC,       4'd0,  8'h00, 8'h00, 32'd0},        1'b1, KIND_GRANT,     4'd2,  32'd1},
		'{'{REQ_ALLOC,       4'd0,  8'h00, 8'h00, 32'd0},        1'b1, KIND_GRANT,     4'd3,  32'd1},
		'{'{REQ_INIT,        4'd0,  8'hFF, 8'h00, 32'd0},        1'b1, KIND_ACK,       4'd0,  32'd1},
		'{'{REQ_INIT,        4'd1,  8'h00, 8'hFF, 32'd0},        1'b1, KIND_ACK,       4'd1,  32'd1},
		'{'{REQ_INIT,        4'd3,  8'hA5, 8'h5A, 32'd0},        1'b1, KIND_ACK,       4'd3,  32'd1},
		'{'{REQ_INIT,        4'd15, 8'h3C, 8'hC3, 32'd0},        1'b1, KIND_ACK,       4'd15, 32'd1},
		'{'{REQ_SET_TIMEOUT, 4'd0,  8'h00, 8'h00, 32'd1},        1'b1, KIND_ACK,       4'd0,  32'd1},
		'{'{REQ_SET_TIMEOUT, 4'd1,  8'h00, 8'h00, 32'd2},        1'b1, KIND_ACK,       4'd1,  32'd1},
		'{'{REQ_SET_TIMEOUT, 4'd3,  8'h00, 8'h00, 32'd1},        1'b1, KIND_ACK,       4'd3,  32'd1},
		// Entry 15 is still free; a timeout starts it anyway.
		'{'{REQ_SET_TIMEOUT, 4'd15, 8'h00, 8'h00, 32'd1},        1'b1, KIND_ACK,       4'd15, 32'd1},
		'{'{REQ_TICK,        4'd0,  8'h00, 8'h00, 32'd0},        1'b0, KIND_ACK,       4'd0,  32'd0},
		'{'{REQ_TICK,        4'd0,  8'h00, 8'h00, 32'd0},        1'b0, KIND_ACK,       4'd0,  32'd0},
		'{'{REQ_INIT,        4'd2,  8'h12, 8'h34, 32'd0},        1'b1, KIND_ACK,       4'd2,  32'd3},
		// A zero timeout wraps and stays far from expiry.
		'{'{REQ_SET_TIMEOUT, 4'd2,  8'h00, 8'h00, 32'd0},        1'b1, KIND_ACK,       4'd2,  32'd3},
		'{'{REQ_SET_TIMEOUT, 4'd0,  8'h00, 8'h00, 32'hFFFFFFFF}, 1'b1, KIND_ACK,       4'd0,  32'd3},
		'{'{REQ_SET_TIMEOUT, 4'd1,  8'h00, 8'h00, 32'd1},        1'b1, KIND_ACK,       4'd1,  32'd3},
		// Freeing a running entry stops it, so the next tick finds nothing.
		'{'{REQ_FREE,        4'd1,  8'h00, 8'h00, 32'd0},        1'b1, KIND_ACK,       4'd1,  32'd3},
		'{'{REQ_TICK,        4'd0,  8'h00, 8'h00, 32'd0},        1'b1, KIND_IDLE_TICK, 4'd0,  32'd4},
		'{'{REQ_RESERVED_LO, 4'd7,  8'h00, 8'h00, 32'd0},        1'b1, KIND_ACK,       4'd7,  32'd4},
		'{'{REQ_RESERVED_HI, 4'd15, 8'hFF, 8'hFF, 32'hFFFFFFFF}, 1'b1, KIND_ACK,       4'd15, 32'd4},
		'{'{REQ_FREE,        4'd3,  8'h00, 8'h00, 32'd0},        1'b1, KIND_ACK,       4'd3,  32'd4},
		'{'{REQ_ALLOC,       4'd0,  8'h00, 8'h00, 32'd0},        1'b0, KIND_ACK,       4'd0,  32'd0}
	};

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Apply one accepted request to the table copy and queue the words it causes.
	function automatic void predict_results(input request_t r);
		result_t found [MAX_ENTRIES];
		int n;
		int i;
		bit granted;
		n = 0;
		granted = 1'b0;
		case (r.req_type)
			REQ_TICK: begin
				ticks_seen = ticks_seen + 1;
				for (i = 0; i < MAX_ENTRIES; i++) begin
					if (slot_state[i] == SLOT_RUNNING) begin
						slot_remaining[i] = slot_remaining[i] - 1;
						if (slot_remaining[i] == '0) begin
							slot_state[i] = SLOT_ALLOCATED;
							found[n] = '{KIND_EXPIRY, ENTRY_W'(i), slot_queue[i], slot_tag[i],
								(i == int'(slice_index)), ticks_seen, 1'b0};
							n++;
						end
					end
				end
				if (n == 0) begin
					pending_results.push_back('{KIND_IDLE_TICK, '0, '0, '0, 1'b0, ticks_seen, 1'b1});
				end else begin
					found[n-1].last = 1'b1;
					for (i = 0; i < n; i++) pending_results.push_back(found[i]);
				end
			end
			REQ_ALLOC: begin
				for (i = 0; i < MAX_ENTRIES && !granted; i++) begin
					if (slot_state[i] == SLOT_FREE) begin
						slot_state[i] = SLOT_ALLOCATED;
						pending_results.push_back('{KIND_GRANT, ENTRY_W'(i), '0, '0, 1'b0,
							ticks_seen, 1'b1});
						granted = 1'b1;
					end
				end
				if (!granted) begin
					pending_results.push_back('{KIND_FAIL, '0, '0, '0, 1'b0, ticks_seen, 1'b1});
				end
			end
			default: begin
				if (r.req_type == REQ_FREE) begin
					slot_state[r.timer_index] = SLOT_FREE;
				end else if (r.req_type == REQ_INIT) begin
					slot_queue[r.timer_index] = r.dest_queue;
					slot_tag[r.timer_index] = r.tag_data;
					slot_tag_written[r.timer_index] = 1'b1;
				end else if (r.req_type == REQ_SET_TIMEOUT) begin
					slot_remaining[r.timer_index] = r.timeout_ticks;
					slot_state[r.timer_index] = SLOT_RUNNING;
				end
				pending_results.push_back('{KIND_ACK, r.timer_index, '0, '0, 1'b0, ticks_seen, 1'b1});
			end
		endcase
	endfunction

	// Offer one request in the current burst, or after a gap, and wait for it.
	task automatic send_request(input request_t r, input bit hand, input result_t hand_res);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(1, 12);
			burst_left = $urandom_range(1, 40);
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid         <= 1'b1;
		req_ch.req_type      <= r.req_type;
		req_ch.timer_index   <= r.timer_index;
		req_ch.dest_queue    <= r.dest_queue;
		req_ch.tag_data      <= r.tag_data;
		req_ch.timeout_ticks <= r.timeout_ticks;
		burst_left--;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		predict_results(r);
		if (hand) pending_results[pending_results.size()-1] = hand_res;
	endtask

	// Read the slice register, write a new value, and read it back.
	task automatic cfg_update_slice(input logic [SLICE_W-1:0] value);
		int step;
		for (step = 0; step < 3; step++) begin
			psel    <= 1'b1;
			penable <= 1'b0;
			pwrite  <= (step == 1);
			paddr   <= SLICE_ADDR;
			pwdata  <= CFG_DATA_W'(value);
			@(posedge clk);
			penable <= 1'b1;
			do @(posedge clk); while (pready !== 1'b1);
			if (step == 1) begin
				slice_index = value;
			end else if (prdata !== CFG_DATA_W'(slice_index)) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("slice register read: expected %0d, got %0d", slice_index, prdata);
			end
		end
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic wait_until_drained();
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Random traffic, mostly well-formed timer use with short timeouts.
	task automatic run_random_phase(input int count, input bit with_hold_off);
		request_t r;
		int accepted;
		int pick;
		int sel;
		int n_inited;
		int i;
		int inited_slots [MAX_ENTRIES];
		accepted = 0;
		while (accepted < count) begin
			pick = $urandom_range(0, 99);
			r.timer_index   = ENTRY_W'($urandom_range(0, MAX_ENTRIES - 1));
			r.dest_queue    = QUEUE_W'($urandom);
			r.tag_data      = TAG_W'($urandom);
			r.timeout_ticks = $urandom;
			if (pick < 35) begin
				r.req_type = REQ_TICK;
			end else if (pick < 50) begin
				r.req_type = REQ_ALLOC;
			end else if (pick < 60) begin
				r.req_type = REQ_FREE;
			end else if (pick < 95) begin
				// Timeouts only go to entries whose tag has been set.
				n_inited = 0;
				for (i = 0; i < MAX_ENTRIES; i++) begin
					if (slot_tag_written[i]) begin
						inited_slots[n_inited] = i;
						n_inited++;
					end
				end
				if (pick < 75 || n_inited == 0) begin
					r.req_type = REQ_INIT;
				end else begin
					r.req_type = REQ_SET_TIMEOUT;
					r.timer_index = ENTRY_W'(inited_slots[$urandom_range(0, n_inited - 1)]);
					sel = $urandom_range(0, 9);
					if (sel < 7) r.timeout_ticks = $urandom_range(1, 6);
					else if (sel < 9) r.timeout_ticks = $urandom_range(7, 40);
				end
			end else begin
				r.req_type = REQ_TYPE_W'($urandom_range(REQ_RESERVED_LO, REQ_RESERVED_HI));
			end
			if (with_hold_off && accepted == 30) hold_off_req = 1'b1;
			send_request(r, 1'b0, '0);
			if (r.req_type <= REQ_SET_TIMEOUT) accepted++;
		end
		req_ch.valid <= 1'b0;
		burst_left = 0;
		wait_until_drained();
	endtask

	// Response side: stretches of steady ready, random stalls and periodic stalls, plus
	// one long hold-off on request.
	initial begin
		int mode;
		int span;
		int c;
		resp_ch.ready = 1'b0;
		forever begin
			mode = $urandom_range(0, 2);
			span = $urandom_range(10, 60);
			for (c = 0; c < span; c++) begin
				@(posedge clk);
				if (hold_off_req) begin
					resp_ch.ready <= 1'b0;
					repeat (HOLD_OFF_CYCLES) @(posedge clk);
					hold_off_req = 1'b0;
				end
				case (mode)
					0: resp_ch.ready <= 1'b1;
					1: resp_ch.ready <= 1'($urandom_range(0, 1));
					default: resp_ch.ready <= (c % 4 != 0);
				endcase
			end
		end
	end

	// Check each response word against the oldest expected one, and stop the
	// run if the block goes quiet for too long.
	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (arst_n && resp_ch.valid === 1'b1 && resp_ch.ready === 1'b1) begin
			got = '{resp_ch.resp_kind, resp_ch.entry_index, resp_ch.notify_queue,
				resp_ch.notify_tag, resp_ch.slice_switch, resp_ch.tick_total, resp_ch.last};
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("unexpected word: kind=%0d entry=%0d queue=%02h tag=%02h",
						got.resp_kind, got.entry_index, got.notify_queue, got.notify_tag);
			end else begin
				want = pending_results.pop_front();
				if (got.resp_kind !== want.resp_kind || got.entry_index !== want.entry_index ||
						got.notify_queue !== want.notify_queue ||
						got.notify_tag !== want.notify_tag ||
						got.slice_switch !== want.slice_switch ||
						got.tick_total !== want.tick_total || got.last !== want.last) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS) begin
						$display("word mismatch, expected: kind=%0d entry=%0d queue=%02h tag=%02h",
							want.resp_kind, want.entry_index, want.notify_queue, want.notify_tag);
						$display("    switch=%0b ticks=%0d last=%0b",
							want.slice_switch, want.tick_total, want.last);
						$display("                    got: kind=%0d entry=%0d queue=%02h tag=%02h",
							got.resp_kind, got.entry_index, got.notify_queue, got.notify_tag);
						$display("    switch=%0b ticks=%0d last=%0b",
							got.slice_switch, got.tick_total, got.last);
					end
				end
			end
		end
		if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
				(resp_ch.valid === 1'b1 && resp_ch.ready === 1'b1)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
			$display("status: fail");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	// Main sequence: reset, directed walk, then random phases per slice setting.
	initial begin
		int k;
		int i;
		arst_n               = 1'b0;
		psel                 = 1'b0;
		penable              = 1'b0;
		pwrite               = 1'b0;
		paddr                = '0;
		pwdata               = '0;
		req_ch.valid         = 1'b0;
		req_ch.req_type      = REQ_TICK;
		req_ch.timer_index   = '0;
		req_ch.dest_queue    = '0;
		req_ch.tag_data      = '0;
		req_ch.timeout_ticks = '0;
		for (i = 0; i < MAX_ENTRIES; i++) begin
			slot_state[i]       = SLOT_FREE;
			slot_remaining[i]   = '0;
			slot_queue[i]       = '0;
			slot_tag[i]         = '0;
			slot_tag_written[i] = 1'b0;
		end
		ticks_seen  = '0;
		slice_index = SLICE_RESET;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Entry 3 is the slice timer during the directed walk.
		cfg_update_slice(5'd3);
		for (k = 0; k < NPLAN; k++) begin
			send_request(plan[k].req, plan[k].hand, '{plan[k].hand_kind, plan[k].hand_entry,
				8'h00, 8'h00, 1'b0, plan[k].hand_total, 1'b1});
		end
		req_ch.valid <= 1'b0;
		burst_left = 0;
		wait_until_drained();

		cfg_update_slice(5'd0);
		run_random_phase(95, 1'b1);
		cfg_update_slice(5'd15);
		run_random_phase(95, 1'b0);
		cfg_update_slice(5'd31);
		run_random_phase(95, 1'b0);
		cfg_update_slice(SLICE_RESET);
		run_random_phase(95, 1'b0);

		if (pending_results.size() != 0) begin
			mismatches += pending_results.size();
			$display("%0d expected words never arrived", pending_results.size());
		end
		if (mismatches == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

// File: filelist.f
rtl/stt_pkg.sv
rtl/stt_if.sv
rtl/stt_apb_regs.sv
rtl/stt_ctrl.sv
rtl/stt_datapath.sv
rtl/software_timer_table.sv
rtl/stt_checker.sv
tb/testbench.sv
